// ----- hw/rtl/fasm_pkg.sv -----
// package: operand and result types for the sign-magnitude float adder
`timescale 1ns / 1ps
`default_nettype none
package fasm_pkg;

  localparam logic [23:0] SIGN24   = 24'h800000;
  localparam logic [23:0] NORM_BIT = 24'h400000;

  typedef struct packed {
    logic signed [7:0] a_exponent;
    logic [23:0]       a_fraction;
    logic signed [7:0] b_exponent;
    logic [23:0]       b_fraction;
  } fasm_in_t;

  typedef struct packed {
    logic signed [7:0] sum_exponent;
    logic [23:0]       sum_fraction;
    logic              exponent_range_error;
  } fasm_out_t;

endpackage
`default_nettype wire

// ----- hw/rtl/float_add_sign_magnitude.sv -----
// top level: four-stage pipelined adder for signed-exponent sign-magnitude floats
// an operand pair passes the stage 1, stage 2, stage 3 and output registers in order before its result is valid
// throughput: one operand pair per cycle while out_ready stays high
// the output stage holds its result while out_ready is low: a stage moves whenever the one ahead is empty or moving
// reset: synchronous, active high, clears all stage valid bits; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module float_add_sign_magnitude import fasm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire fasm_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output fasm_out_t      out_data
);

  logic v1, v2, v3, v4;
  logic mv1, mv2, mv3, mv4;

  // stage 1: two's complement, exponent difference
  logic signed [31:0] s1_fa, s1_fb;
  logic signed [8:0]  s1_diff;
  logic signed [7:0]  s1_ea, s1_eb;
  // stage 2: aligned sum
  logic signed [31:0] s2_sum;
  logic signed [9:0]  s2_e;
  // stage 3: magnitude and leading zero count
  logic [31:0]        s3_mag;
  logic               s3_neg, s3_zero;
  logic signed [9:0]  s3_e;
  logic [4:0]         s3_lz;

  assign mv4 = v4 && out_ready;
  assign mv3 = v3 && (!v4 || mv4);
  assign mv2 = v2 && (!v3 || mv3);
  assign mv1 = v1 && (!v2 || mv2);
  assign in_ready = !v1 || mv1;
  assign out_valid = v4;

  function automatic logic signed [31:0] to_twos(input logic [23:0] f);
    logic signed [31:0] m;
    m = {9'd0, f[22:0]};
    return f[23] ? -m : m;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else begin
      if (in_ready) v1 <= in_valid;
      if (!v2 || mv2) v2 <= mv1;
      if (!v3 || mv3) v3 <= mv2;
      if (!v4 || mv4) v4 <= mv3;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_fa   <= to_twos(in_data.a_fraction);
      s1_fb   <= to_twos(in_data.b_fraction);
      s1_ea   <= in_data.a_exponent;
      s1_eb   <= in_data.b_exponent;
      s1_diff <= 9'(in_data.a_exponent) - 9'(in_data.b_exponent);
    end
  end

  logic signed [31:0] s1_fa_sh, s1_fb_sh;
  logic [4:0]         s1_amt;
  logic [8:0]         s1_ndiff;
  always_comb begin
    s1_ndiff = -s1_diff;
    if (s1_diff > 0) s1_amt = (s1_diff > 9'sd31) ? 5'd31 : s1_diff[4:0];
    else             s1_amt = (s1_ndiff > 9'd31) ? 5'd31 : s1_ndiff[4:0];
    s1_fa_sh = (s1_diff > 0) ? s1_fa : (s1_fa >>> s1_amt);
    s1_fb_sh = (s1_diff > 0) ? (s1_fb >>> s1_amt) : s1_fb;
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      s2_sum <= s1_fa_sh + s1_fb_sh;
      s2_e   <= (s1_diff > 0) ? 10'(s1_ea) : 10'(s1_eb);
    end
  end

  logic [31:0] s2_mag;
  logic [4:0]  s2_lz;
  always_comb begin
    s2_mag = s2_sum[31] ? 32'(-s2_sum) : 32'(s2_sum);
    s2_lz = 5'd0;
    for (int i = 0; i <= 22; i++) begin
      if (s2_mag[i]) s2_lz = 5'(22 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      s3_mag  <= s2_mag;
      s3_neg  <= s2_sum[31];
      s3_zero <= (s2_sum == 32'sd0);
      s3_e    <= s2_e;
      s3_lz   <= s2_lz;
    end
  end

  logic [31:0]       s3_norm;
  logic signed [9:0] s3_ef;
  always_comb begin
    if (s3_mag[23]) begin
      s3_norm = s3_mag >> 1;
      s3_ef   = s3_e + 10'sd1;
    end else begin
      s3_norm = s3_mag << s3_lz;
      s3_ef   = s3_e - 10'(s3_lz);
    end
  end

  always_ff @(posedge clk) begin
    if (mv3) begin
      if (s3_zero) begin
        out_data.sum_exponent         <= s3_e[7:0];
        out_data.sum_fraction         <= 24'd0;
        out_data.exponent_range_error <= 1'b0;
      end else begin
        out_data.sum_exponent         <= s3_ef[7:0];
        out_data.sum_fraction         <= {s3_neg, s3_norm[22:0]};
        out_data.exponent_range_error <= (s3_ef < -10'sd128) || (s3_ef > 10'sd127);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fasm_checker.sv -----
// checker: port-level properties of the float adder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module fasm_checker import fasm_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire fasm_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sum_fraction == 24'd0 |-> !out_data.exponent_range_error)
    else $error("zero sum flagged");

  a_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sum_fraction != 24'd0 |-> out_data.sum_fraction[22])
    else $error("result not normalized");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after four cycles");

endmodule

bind float_add_sign_magnitude fasm_checker u_fasm_checker (.*);
`default_nettype wire
